// ===== hw/rtl/tbwp_pkg.sv =====
// ============================================================================
// tbwp_pkg
// Shared constants for the tile background/window pixel unit.
// ============================================================================
package tbwp_pkg;

  // Video memory geometry (byte offsets from the start of video memory)
  localparam int VRAM_BYTES  = 8192;
  localparam int VRAM_AW     = 13;
  localparam int MAP_DEPTH   = 2048;   // tile maps occupy the top 2 KiB
  localparam int MAP_AW      = 11;
  localparam int PLANE_DEPTH = 4096;   // one bit plane of all tile rows
  localparam int PLANE_AW    = 12;

  // Map region tag: address bits [12:11] of the two tile maps
  localparam logic [1:0] MAP_REGION = 2'b11;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DISP_CTRL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_SCROLL_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_SCROLL_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BG_PALETTE  = 3'd5;

  // Display control bit positions
  localparam int LCDC_DISPLAY_EN = 7;
  localparam int LCDC_WIN_MAP    = 6;
  localparam int LCDC_WIN_EN     = 5;
  localparam int LCDC_TILE_DATA  = 4;
  localparam int LCDC_BG_MAP     = 3;
  localparam int LCDC_LAYER_EN   = 0;

  // Input word modes
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_RENDER = 1'b1;

  // Window left edge offset
  localparam logic [8:0] WIN_X_OFFSET = 9'd7;

endpackage

// ===== hw/rtl/tbwp_ram.sv =====
// ============================================================================
// tbwp_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module tbwp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds while the consumer stage is stalled
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/tile_background_window_pixel_unit.sv =====
// ============================================================================
// tile_background_window_pixel_unit
// Background and window pixel source over an 8 KiB tile video memory.
// ============================================================================
// Takes one word per clock unless in_stall is high, and returns one pixel
// word per render request. A render request passes through stages 1 to 4
// and is held in the stage 4 output register until it is taken. Write words
// (mode 0) update video memory and return nothing; render words (mode 1)
// pick the window or background layer, read the tile number from the tile
// map, read both bit planes of the tile row, and map the 2-bit color through
// bg_palette. The two dependent memory reads set the four-stage depth; each
// stage holds one word, so with no stall the rate is one word per clock.
// Writes travel down the pipe with the renders and land in each memory copy
// at the stage that reads it, so a render sees exactly the writes accepted
// before it. Video memory is held as three RAMs: the 2 KiB map area, and
// the even (low plane) and odd (high plane) bytes of tile data; there is no
// clearing pass. Registers must be written only while the unit is idle.
// ============================================================================
module tile_background_window_pixel_unit
  import tbwp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration write port
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  // input words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 mode,
  input  logic [VRAM_AW-1:0]   vram_address,
  input  logic [7:0]           vram_data,
  input  logic [7:0]           pixel_x,
  input  logic [7:0]           screen_line,
  // result words
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           shade,
  output logic [1:0]           color_index,
  output logic                 from_window,
  output logic                 visible
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0] disp_ctrl;
  logic [7:0] bg_scroll_y;
  logic [7:0] bg_scroll_x;
  logic [7:0] window_y;
  logic [7:0] window_x;
  logic [7:0] bg_palette;

  always_ff @(posedge clk) begin
    if (rst) begin
      disp_ctrl   <= '0;
      bg_scroll_y <= '0;
      bg_scroll_x <= '0;
      window_y    <= '0;
      window_x    <= '0;
      bg_palette  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DISP_CTRL:   disp_ctrl   <= cfg_data;
        CFG_BG_SCROLL_Y: bg_scroll_y <= cfg_data;
        CFG_BG_SCROLL_X: bg_scroll_x <= cfg_data;
        CFG_WINDOW_Y:    window_y    <= cfg_data;
        CFG_WINDOW_X:    window_x    <= cfg_data;
        CFG_BG_PALETTE:  bg_palette  <= cfg_data;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its word moves on
  // --------------------------------------------------------------------------
  logic v1, v2, v3, v4;
  logic ready1, ready2, ready3, ready4;

  assign ready4   = !v4 || !out_stall;
  assign ready3   = !v3 || ready4;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_stall = !ready1;

  // --------------------------------------------------------------------------
  // Stage 1: layer select and map coordinates
  // --------------------------------------------------------------------------
  logic [8:0] win_reach;
  logic       win_hit;
  logic [7:0] layer_x;
  logic [7:0] layer_y;
  logic       map_sel;

  always_comb begin
    win_reach = {1'b0, pixel_x} + WIN_X_OFFSET;
    win_hit   = disp_ctrl[LCDC_WIN_EN] && (screen_line >= window_y) &&
                (win_reach >= {1'b0, window_x});
    if (win_hit) begin
      layer_x = 8'(win_reach - {1'b0, window_x});
      layer_y = screen_line - window_y;
      map_sel = disp_ctrl[LCDC_WIN_MAP];
    end else begin
      layer_x = pixel_x + bg_scroll_x;
      layer_y = screen_line + bg_scroll_y;
      map_sel = disp_ctrl[LCDC_BG_MAP];
    end
  end

  logic               s1_mode;
  logic [VRAM_AW-1:0] s1_waddr;
  logic [7:0]         s1_wdata;
  logic [MAP_AW-1:0]  s1_map_addr;
  logic [2:0]         s1_fine_x;
  logic [2:0]         s1_fine_y;
  logic               s1_win;
  logic               s1_blank;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ready1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      s1_mode     <= mode;
      s1_waddr    <= vram_address;
      s1_wdata    <= vram_data;
      s1_map_addr <= {map_sel, layer_y[7:3], layer_x[7:3]};
      s1_fine_x   <= layer_x[2:0];
      s1_fine_y   <= layer_y[2:0];
      s1_win      <= win_hit;
      s1_blank    <= !disp_ctrl[LCDC_DISPLAY_EN] || !disp_ctrl[LCDC_LAYER_EN];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: tile map read (writes to the map area land here too)
  // --------------------------------------------------------------------------
  logic [7:0] map_tile;
  logic       map_wr_en;

  assign map_wr_en = ready2 && v1 && (s1_mode == MODE_WRITE) &&
                     (s1_waddr[VRAM_AW-1 -: 2] == MAP_REGION);

  tbwp_ram #(
    .WIDTH (8),
    .DEPTH (MAP_DEPTH)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (map_wr_en),
    .wr_addr (s1_waddr[MAP_AW-1:0]),
    .wr_data (s1_wdata),
    .rd_en   (ready2),
    .rd_addr (s1_map_addr),
    .rd_data (map_tile)
  );

  logic               s2_mode;
  logic [VRAM_AW-1:0] s2_waddr;
  logic [7:0]         s2_wdata;
  logic [2:0]         s2_fine_x;
  logic [2:0]         s2_fine_y;
  logic               s2_win;
  logic               s2_blank;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_mode   <= s1_mode;
      s2_waddr  <= s1_waddr;
      s2_wdata  <= s1_wdata;
      s2_fine_x <= s1_fine_x;
      s2_fine_y <= s1_fine_y;
      s2_win    <= s1_win;
      s2_blank  <= s1_blank;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: tile row read, both planes at once
  // --------------------------------------------------------------------------
  // Signed tile numbers 0..127 sit 0x1000 above the unsigned base; 128..255
  // share the unsigned location.
  logic [PLANE_AW-1:0] plane_addr;
  logic                plane_write;
  logic                lo_wr_en;
  logic                hi_wr_en;
  logic [7:0]          lo_plane;
  logic [7:0]          hi_plane;

  assign plane_addr  = {!disp_ctrl[LCDC_TILE_DATA] && !map_tile[7], map_tile, s2_fine_y};
  assign plane_write = ready3 && v2 && (s2_mode == MODE_WRITE);
  assign lo_wr_en    = plane_write && !s2_waddr[0];
  assign hi_wr_en    = plane_write && s2_waddr[0];

  tbwp_ram #(
    .WIDTH (8),
    .DEPTH (PLANE_DEPTH)
  ) u_lo_ram (
    .clk     (clk),
    .wr_en   (lo_wr_en),
    .wr_addr (s2_waddr[VRAM_AW-1:1]),
    .wr_data (s2_wdata),
    .rd_en   (ready3),
    .rd_addr (plane_addr),
    .rd_data (lo_plane)
  );

  tbwp_ram #(
    .WIDTH (8),
    .DEPTH (PLANE_DEPTH)
  ) u_hi_ram (
    .clk     (clk),
    .wr_en   (hi_wr_en),
    .wr_addr (s2_waddr[VRAM_AW-1:1]),
    .wr_data (s2_wdata),
    .rd_en   (ready3),
    .rd_addr (plane_addr),
    .rd_data (hi_plane)
  );

  logic       s3_mode;
  logic [2:0] s3_fine_x;
  logic       s3_win;
  logic       s3_blank;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ready3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3) begin
      s3_mode   <= s2_mode;
      s3_fine_x <= s2_fine_x;
      s3_win    <= s2_win;
      s3_blank  <= s2_blank;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: pixel color and palette, output register
  // --------------------------------------------------------------------------
  // bit 7 of each plane is the leftmost pixel
  logic [2:0] bit_sel;
  logic [1:0] pix_color;
  logic [1:0] pix_shade;

  always_comb begin
    bit_sel   = 3'd7 - s3_fine_x;
    pix_color = {hi_plane[bit_sel], lo_plane[bit_sel]};
    pix_shade = 2'(bg_palette >> {pix_color, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ready4) begin
      v4 <= v3 && (s3_mode == MODE_RENDER);  // write words end here
    end
  end

  always_ff @(posedge clk) begin
    if (ready4) begin
      if (s3_blank) begin
        shade       <= 2'd0;
        color_index <= 2'd0;
        from_window <= 1'b0;
        visible     <= 1'b0;
      end else begin
        shade       <= pix_shade;
        color_index <= pix_color;
        from_window <= s3_win;
        visible     <= 1'b1;
      end
    end
  end

  assign out_valid = v4;

endmodule

// ===== hw/rtl/tbwp_checker.sv =====
// ============================================================================
// tbwp_checker
// Port-level checks of the tile background/window pixel unit.
// ============================================================================
module tbwp_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] shade,
  input logic [1:0] color_index,
  input logic       from_window,
  input logic       visible
);

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word right after reset");

  // a blanked pixel carries all-zero fields
  a_blank_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !visible) |-> (shade == 2'd0 && color_index == 2'd0 && !from_window))
    else $error("blank pixel with nonzero fields");

  // the window only supplies visible pixels
  a_window_visible: assert property (@(posedge clk) disable iff (rst)
    (out_valid && from_window) |-> visible)
    else $error("window pixel not visible");

  // a stalled result word is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result word dropped");

endmodule

bind tile_background_window_pixel_unit tbwp_checker u_tbwp_checker (.*);

// ===== tb/tile_background_window_pixel_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tile_background_window_pixel_unit_tb
// Self-checking bench for the background/window pixel unit. A scoreboard
// keeps a shadow of video memory and the registers, predicts every pixel
// word from the render requests the unit accepts, and checks the returned
// pixels in order. Stimulus is a short directed pass over the layer rules
// and edge cases, then randomized phases with fixed or random register settings.
// Both handshakes see random idle and stall gaps.
// ----------------------------------------------------------------------------
module tile_background_window_pixel_unit_tb;
  import tbwp_pkg::*;

  localparam logic [12:0] MAP_LOW_BASE     = 13'h1800;  // 0x9800
  localparam logic [12:0] MAP_HIGH_BASE    = 13'h1C00;  // 0x9C00
  localparam logic [12:0] SIGNED_TILE_BASE = 13'h1000;  // 0x9000
  localparam int RANDOM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE    = 125;
  localparam int HOLD_OFF_PHASE     = 2;
  localparam int HOLD_OFF_CYCLES    = 300;
  localparam int DRAIN_LIMIT        = 20000;
  localparam int PIPE_SETTLE_CYCLES = 12;   // pipe is four deep
  localparam int RUN_LIMIT_NS       = 10_000_000;

  typedef struct packed {
    logic [1:0] shade;
    logic [1:0] color_index;
    logic       from_window;
    logic       visible;
  } pixel_t;

  // Shadow of the unit: registers, video memory and the pixels still owed.
  class PixelScoreboard;
    logic [7:0] regs [6];
    logic [7:0] vram [VRAM_BYTES];
    bit         written [VRAM_BYTES];
    pixel_t     expected_pixels [$];
    int         errors;

    function new();
      foreach (regs[i]) regs[i] = 8'h00;
      errors = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
      regs[idx] = v;
    endfunction

    function bit layer_on();
      return regs[CFG_DISP_CTRL][LCDC_DISPLAY_EN] && regs[CFG_DISP_CTRL][LCDC_LAYER_EN];
    endfunction

    // Layer choice, tile map address and the pixel's place inside its tile.
    function void locate(input logic [7:0] x, input logic [7:0] line, output bit win,
                         output logic [12:0] map_a, output logic [2:0] col,
                         output logic [2:0] row);
      logic [7:0] lcdc;
      logic [7:0] px;
      logic [7:0] py;
      lcdc = regs[CFG_DISP_CTRL];
      win = lcdc[LCDC_WIN_EN] && (line >= regs[CFG_WINDOW_Y]) &&
            ({1'b0, x} + WIN_X_OFFSET >= {1'b0, regs[CFG_WINDOW_X]});
      if (win) begin
        px = x + WIN_X_OFFSET[7:0] - regs[CFG_WINDOW_X];
        py = line - regs[CFG_WINDOW_Y];
        map_a = lcdc[LCDC_WIN_MAP] ? MAP_HIGH_BASE : MAP_LOW_BASE;
      end else begin
        px = x + regs[CFG_BG_SCROLL_X];
        py = line + regs[CFG_BG_SCROLL_Y];
        map_a = lcdc[LCDC_BG_MAP] ? MAP_HIGH_BASE : MAP_LOW_BASE;
      end
      map_a = map_a + {py[7:3], px[7:3]};
      col = px[2:0];
      row = py[2:0];
    endfunction

    // Low-plane byte of a tile row; the high plane follows it.
    function logic [12:0] plane_addr(input logic [7:0] tile, input logic [2:0] row);
      logic [12:0] a;
      if (regs[CFG_DISP_CTRL][LCDC_TILE_DATA] || tile[7])
        a = {1'b0, tile, 4'b0000};
      else
        a = SIGNED_TILE_BASE + {tile, 4'b0000};
      return a + {row, 1'b0};
    endfunction

    function pixel_t predict_pixel(input logic [7:0] x, input logic [7:0] line);
      pixel_t      p;
      bit          win;
      logic [12:0] map_a;
      logic [12:0] lo_a;
      logic [2:0]  col;
      logic [2:0]  row;
      logic [1:0]  c;
      logic [7:0]  pal;
      p = '0;
      if (!layer_on()) return p;
      locate(x, line, win, map_a, col, row);
      lo_a = plane_addr(vram[map_a], row);
      c = {vram[lo_a + 13'd1][3'd7 - col], vram[lo_a][3'd7 - col]};
      pal = regs[CFG_BG_PALETTE];
      p.shade = pal[{c, 1'b0} +: 2];
      p.color_index = c;
      p.from_window = win;
      p.visible = 1'b1;
      return p;
    endfunction

    function void note_word(input logic m, input logic [12:0] a, input logic [7:0] d,
                            input logic [7:0] x, input logic [7:0] line);
      if (m == MODE_WRITE) begin
        vram[a] = d;
        written[a] = 1'b1;
      end else begin
        expected_pixels = {expected_pixels, predict_pixel(x, line)};
      end
    endfunction

    function void compare_field(input string name, input logic [1:0] e, input logic [1:0] g);
      if (g !== e) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, e, g);
      end
    endfunction

    function void check_pixel(input logic [1:0] sh, input logic [1:0] ci, input logic fw,
                              input logic vis);
      pixel_t e;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: pixel word with no pending request: expected none, actual %b",
                 $time, {sh, ci, fw, vis});
        return;
      end
      e = expected_pixels.pop_front();
      compare_field("shade", e.shade, sh);
      compare_field("color_index", e.color_index, ci);
      compare_field("from_window", {1'b0, e.from_window}, {1'b0, fw});
      compare_field("visible", {1'b0, e.visible}, {1'b0, vis});
    endfunction

    function void report_leftovers();
      if (expected_pixels.size() != 0) begin
        errors++;
        $display("%0t: pending pixels: expected 0, actual %0d", $time,
                 expected_pixels.size());
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 mode;
  logic [VRAM_AW-1:0]   vram_address;
  logic [7:0]           vram_data;
  logic [7:0]           pixel_x;
  logic [7:0]           screen_line;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           shade;
  logic [1:0]           color_index;
  logic                 from_window;
  logic                 visible;

  PixelScoreboard sb;
  bit hold_off_req;   // asks the receiver for one long stall
  bit drain_quiet;    // receiver starts no new random stall while the pipe drains
  int burst_left;     // words still to send back to back
  int words_sent;     // input words accepted so far

  tile_background_window_pixel_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .vram_address (vram_address),
    .vram_data    (vram_data),
    .pixel_x      (pixel_x),
    .screen_line  (screen_line),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .shade        (shade),
    .color_index  (color_index),
    .from_window  (from_window),
    .visible      (visible)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case a handshake never completes.
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("TB_ERROR");
    $finish;
  end

  // Sender idle time: mostly none, some short gaps, a few long ones.
  function automatic int sender_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one input word and hold it until the unit takes it. Called at a
  // rising edge; returns at the edge that accepted the word, with the
  // scoreboard already updated, so the next word can depend on it.
  task automatic drive_word(input logic m, input logic [12:0] a, input logic [7:0] d,
                            input logic [7:0] x, input logic [7:0] line);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    vram_address <= a;
    vram_data    <= d;
    pixel_x      <= x;
    screen_line  <= line;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_word(m, a, d, x, line);
    words_sent++;
  endtask

  task automatic drive_write(input logic [12:0] a, input logic [7:0] d);
    drive_word(MODE_WRITE, a, d, 8'($urandom), 8'($urandom));
  endtask

  // Render request. Any of the three bytes the pixel will read that has not
  // been written yet gets a random value first; video memory has no defined
  // reset contents, so an unwritten byte must never be read.
  task automatic render_pixel(input logic [7:0] x, input logic [7:0] line);
    bit          win;
    logic [12:0] map_a;
    logic [12:0] lo_a;
    logic [2:0]  col;
    logic [2:0]  row;
    if (sb.layer_on()) begin
      sb.locate(x, line, win, map_a, col, row);
      if (!sb.written[map_a]) drive_write(map_a, 8'($urandom));
      lo_a = sb.plane_addr(sb.vram[map_a], row);
      if (!sb.written[lo_a]) drive_write(lo_a, 8'($urandom));
      if (!sb.written[lo_a + 13'd1]) drive_write(lo_a + 13'd1, 8'($urandom));
    end
    drive_word(MODE_RENDER, 13'($urandom), 8'($urandom), x, line);
  endtask

  // Stop sending, let every owed pixel come back, then give the pipe time
  // to retire trailing writes so the unit is idle for register writes.
  task automatic settle();
    int n;
    in_valid <= 1'b0;
    drain_quiet = 1'b1;
    n = 0;
    while (sb.expected_pixels.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (PIPE_SETTLE_CYCLES) @(posedge clk);
    drain_quiet = 1'b0;
  endtask

  // Write all six registers on back-to-back cycles.
  task automatic apply_config(input logic [7:0] lcdc, input logic [7:0] scy,
                              input logic [7:0] scx, input logic [7:0] wy,
                              input logic [7:0] wx, input logic [7:0] pal);
    logic [7:0]           vals [6];
    logic [CFG_IDX_W-1:0] reg_idx [6];
    vals = '{lcdc, scy, scx, wy, wx, pal};
    reg_idx = '{CFG_DISP_CTRL, CFG_BG_SCROLL_Y, CFG_BG_SCROLL_X,
                CFG_WINDOW_Y, CFG_WINDOW_X, CFG_BG_PALETTE};
    foreach (vals[i]) begin
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= reg_idx[i];
      cfg_data  <= vals[i];
      sb.set_reg(reg_idx[i], vals[i]);
    end
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Coordinate biased to the screen, its corners, the window edge and the
  // off-screen range.
  function automatic logic [7:0] pick_coord(input logic [7:0] screen_max,
                                            input logic [7:0] edge_pos);
    int roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       return 8'd0;
      1:       return screen_max;
      2:       return 8'd255;
      3, 4:    return 8'(edge_pos + $urandom_range(0, 2) - 1);
      5:       return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, screen_max));
    endcase
  endfunction

  // Writes lean toward the tile maps so renders see rewritten tile numbers.
  function automatic logic [12:0] pick_address();
    if ($urandom_range(0, 1) == 0) return 13'(MAP_LOW_BASE + $urandom_range(0, 2047));
    return 13'($urandom_range(0, VRAM_BYTES - 1));
  endfunction

  // Receiver: random stalls, quiet stretches, and one long hold-off on
  // request that backs the pipe up into the input.
  initial begin : receiver
    int roll;
    out_stall <= 1'b0;
    wait (rst == 1'b0);
    forever begin
      roll = $urandom_range(0, 19);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (drain_quiet || roll < 12) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else if (roll == 12) begin
        out_stall <= 1'b0;
        repeat (60) @(posedge clk);
      end else if (roll < 19) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  // Every pixel word taken from the unit goes to the scoreboard.
  always @(posedge clk) begin
    if (rst === 1'b0 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_pixel(shade, color_index, from_window, visible);
  end

  initial begin : main
    int roll;
    int phase_end;
    sb = new();
    hold_off_req = 1'b0;
    drain_quiet  = 1'b0;
    burst_left   = 0;
    words_sent   = 0;
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= CFG_DISP_CTRL;
    cfg_data     <= 8'h00;
    in_valid     <= 1'b0;
    mode         <= MODE_WRITE;
    vram_address <= '0;
    vram_data    <= 8'h00;
    pixel_x      <= 8'h00;
    screen_line  <= 8'h00;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed ---
    // Registers at reset: display off, so a render is blank.
    render_pixel(8'd0, 8'd0);
    drive_write(13'd0, 8'h00);
    drive_write(13'(VRAM_BYTES - 1), 8'hFF);
    drive_write(MAP_LOW_BASE, 8'h7F);
    settle();

    // Signed tile numbers: 127 is the last tile above 0x9000, 128 wraps to
    // 0x8800. Then the screen corners and the off-screen corner.
    apply_config(8'h81, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE4);
    render_pixel(8'd0, 8'd0);
    drive_write(MAP_LOW_BASE, 8'h80);
    render_pixel(8'd0, 8'd0);
    render_pixel(8'd159, 8'd143);
    render_pixel(8'd255, 8'd255);
    settle();

    // Window edges: column WX-7 and line WY are the first window pixels.
    apply_config(8'hFF, 8'hFF, 8'hFF, 8'd10, 8'd20, 8'h1B);
    render_pixel(8'd13, 8'd10);
    render_pixel(8'd12, 8'd10);
    render_pixel(8'd13, 8'd9);
    render_pixel(8'd255, 8'd255);
    settle();

    // WX below 7: window starts left of the screen and its x wraps.
    apply_config(8'hA1, 8'd3, 8'd5, 8'd0, 8'd0, 8'hE4);
    render_pixel(8'd0, 8'd0);
    render_pixel(8'd255, 8'd0);
    settle();

    // Display on with layers off, then layers on with display off.
    apply_config(8'h80, 8'd3, 8'd5, 8'd0, 8'd0, 8'hE4);
    render_pixel(8'd40, 8'd40);
    settle();
    apply_config(8'h01, 8'd3, 8'd5, 8'd0, 8'd0, 8'hE4);
    render_pixel(8'd40, 8'd40);

    // --- random phases ---
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      case (p)
        0:       apply_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        1:       apply_config(8'hB1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        default: apply_config(8'($urandom | (($urandom_range(0, 3) != 0) ? 8'h81 : 8'h00)),
                              8'($urandom), 8'($urandom),
                              8'(($urandom_range(0, 3) == 0) ? $urandom
                                                             : $urandom_range(0, 143)),
                              8'(($urandom_range(0, 3) == 0) ? $urandom
                                                             : $urandom_range(0, 166)),
                              8'($urandom));
      endcase
      if (p == HOLD_OFF_PHASE) hold_off_req = 1'b1;
      // words that fill unwritten bytes count toward the phase too
      phase_end = words_sent + ITEMS_PER_PHASE;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 29) == 0) burst_left = 30;
        roll = $urandom_range(0, 9);
        if (roll < 4)
          drive_write(pick_address(), 8'($urandom));
        else
          render_pixel(pick_coord(8'd159, sb.regs[CFG_WINDOW_X] - 8'd7),
                       pick_coord(8'd143, sb.regs[CFG_WINDOW_Y]));
      end
    end

    settle();
    sb.report_leftovers();
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== tile_background_window_pixel_unit.f =====
hw/rtl/tbwp_pkg.sv
hw/rtl/tbwp_ram.sv
hw/rtl/tile_background_window_pixel_unit.sv
hw/rtl/tbwp_checker.sv
tb/tile_background_window_pixel_unit_tb.sv
